[rtl/tdfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfe_pkg
// Shared constants, command codes, register map and types of the
// table-driven state machine engine.
// ----------------------------------------------------------------------------
package tdfe_pkg;

	localparam int INSTANCES   = 3;
	localparam int ENTRIES     = 16;
	localparam int STATE_BITS  = 8;
	localparam int OP_W        = 8;
	localparam int CNT_W       = 5;
	localparam int INST_W      = 2;
	localparam int SLOT_W      = 4;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int DEPTH       = INSTANCES * ENTRIES;
	localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_EVENT = 2'd1;
	localparam logic [1:0] CMD_FORCE = 2'd2;
	localparam logic [1:0] CMD_JUMP  = 2'd3;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_CNT0    = 3'd0;
	localparam logic [2:0] REG_CNT1    = 3'd1;
	localparam logic [2:0] REG_CNT2    = 3'd2;
	localparam logic [2:0] REG_MASK    = 3'd3;
	localparam logic [2:0] REG_INIT_OP = 3'd4;

	typedef struct packed {
		logic                  act;
		logic [STATE_BITS-1:0] to;
		logic [OP_W-1:0]       op;
		logic [STATE_BITS-1:0] from;
	} entry_t;

	typedef struct packed {
		logic [INSTANCES-1:0][CNT_W-1:0] entries_used;
		logic [INSTANCES-1:0]            notify_mask;
		logic [OP_W-1:0]                 init_op;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [INST_W-1:0] inst;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        key_state;
		logic [OP_W-1:0]   operation;
		logic [7:0]        to_state;
		logic              has_action;
	} item_t;

	typedef struct packed {
		logic              matched;
		logic [INST_W-1:0] inst;
		logic [7:0]        prior_state;
		logic [7:0]        present_state;
		logic [OP_W-1:0]   last_operation;
		logic              public_notify;
		logic              action_notify;
		logic [7:0]        action_from;
		logic [7:0]        action_to;
	} res_t;

	typedef struct packed {
		logic load_item;
		logic scan_en;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic done;
	} dp_stat_t;

endpackage

[rtl/tdfe_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfe_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module tdfe_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tdfe_pkg::PADDR_W-1:0]     paddr,
	input  logic [tdfe_pkg::PDATA_W-1:0]     pwdata,
	output logic [tdfe_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	output tdfe_pkg::cfg_t                   cfg
);

	tdfe_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			case (idx)
				tdfe_pkg::REG_CNT0:    cfg_q.entries_used[0] <= pwdata[tdfe_pkg::CNT_W-1:0];
				tdfe_pkg::REG_CNT1:    cfg_q.entries_used[1] <= pwdata[tdfe_pkg::CNT_W-1:0];
				tdfe_pkg::REG_CNT2:    cfg_q.entries_used[2] <= pwdata[tdfe_pkg::CNT_W-1:0];
				tdfe_pkg::REG_MASK:    cfg_q.notify_mask <= pwdata[tdfe_pkg::INSTANCES-1:0];
				tdfe_pkg::REG_INIT_OP: cfg_q.init_op <= pwdata[tdfe_pkg::OP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			tdfe_pkg::REG_CNT0:    prdata[tdfe_pkg::CNT_W-1:0] = cfg_q.entries_used[0];
			tdfe_pkg::REG_CNT1:    prdata[tdfe_pkg::CNT_W-1:0] = cfg_q.entries_used[1];
			tdfe_pkg::REG_CNT2:    prdata[tdfe_pkg::CNT_W-1:0] = cfg_q.entries_used[2];
			tdfe_pkg::REG_MASK:    prdata[tdfe_pkg::INSTANCES-1:0] = cfg_q.notify_mask;
			tdfe_pkg::REG_INIT_OP: prdata[tdfe_pkg::OP_W-1:0] = cfg_q.init_op;
			default: ;
		endcase
	end

endmodule

[rtl/tdfe_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfe_ctrl
// Sequencer: takes one beat, runs the table scan, hands the result to the
// output register when it is free.
// ----------------------------------------------------------------------------
module tdfe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  tdfe_pkg::dp_stat_t    stat,
	output tdfe_pkg::ctrl_cmd_t   cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q;
	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd.load_item = (state_q == ST_IDLE) && s_tvalid;
		cmd.scan_en   = (state_q == ST_BUSY) && !stat.done;
		cmd.commit    = (state_q == ST_BUSY) && stat.done && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_BUSY;
				end
				ST_BUSY: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

endmodule

[rtl/tdfe_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfe_dp
// Datapath: transition table memory, per-instance state registers, scan
// counter and compare, result register.
// ----------------------------------------------------------------------------
module tdfe_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tdfe_pkg::item_t       item,
	input  tdfe_pkg::cfg_t        cfg,
	input  tdfe_pkg::ctrl_cmd_t   cmd,
	output tdfe_pkg::dp_stat_t    stat,
	output tdfe_pkg::res_t        res
);

	localparam int SB = tdfe_pkg::STATE_BITS;

	tdfe_pkg::entry_t mem [tdfe_pkg::DEPTH];

	logic [tdfe_pkg::INSTANCES-1:0][SB-1:0]             prev_q, cur_q;
	logic [tdfe_pkg::INSTANCES-1:0][tdfe_pkg::OP_W-1:0] rop_q;

	logic [1:0]                  cmd_q;
	logic [tdfe_pkg::INST_W-1:0] inst_q;
	logic [tdfe_pkg::SLOT_W-1:0] slot_q;
	logic [SB-1:0]               key_q, to_q, lookup_q;
	logic [tdfe_pkg::OP_W-1:0]   op_q;
	logic                        act_q;
	logic [tdfe_pkg::CNT_W-1:0]  n_q, idx_q;
	logic                        issue_s1;
	tdfe_pkg::entry_t            rd_s1;
	tdfe_pkg::res_t              res_q;

	logic                        in_ok, inst_ok, slot_ok, need_scan, hit, exhausted;
	logic [tdfe_pkg::CNT_W-1:0]  cnt_in;
	logic [tdfe_pkg::ADDR_W-1:0] rd_addr, wr_addr;
	logic                        wr_en;
	logic [SB-1:0]               prev_old, cur_old, prev_n, cur_n;
	logic [tdfe_pkg::OP_W-1:0]   rop_old, rop_n;
	tdfe_pkg::res_t              res_n;

	assign in_ok   = 32'(item.inst) < tdfe_pkg::INSTANCES;
	assign inst_ok = 32'(inst_q) < tdfe_pkg::INSTANCES;
	assign slot_ok = 32'(slot_q) < tdfe_pkg::ENTRIES;
	assign cnt_in  = in_ok ? cfg.entries_used[item.inst] : '0;

	// capture the item; events look up with the current state as key
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q  <= item.command;
			inst_q <= item.inst;
			slot_q <= item.slot;
			key_q  <= item.key_state[SB-1:0];
			to_q   <= item.to_state[SB-1:0];
			op_q   <= item.operation;
			act_q  <= item.has_action;
			n_q    <= (32'(cnt_in) > tdfe_pkg::ENTRIES) ?
			          tdfe_pkg::CNT_W'(tdfe_pkg::ENTRIES) : cnt_in;
			if (item.command == tdfe_pkg::CMD_EVENT && in_ok)
				lookup_q <= cur_q[item.inst];
			else
				lookup_q <= item.key_state[SB-1:0];
		end
	end

	// scan: one table read issued per cycle, compared in the cycle after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			issue_s1 <= 1'b0;
		end else if (cmd.load_item) begin
			idx_q    <= '0;
			issue_s1 <= 1'b0;
		end else if (cmd.scan_en) begin
			issue_s1 <= (idx_q < n_q);
			if (idx_q < n_q) idx_q <= idx_q + 1'b1;
		end
	end

	assign rd_addr = tdfe_pkg::ADDR_W'(32'(inst_q) * tdfe_pkg::ENTRIES
	                                   + 32'(idx_q[tdfe_pkg::IDX_W-1:0]));
	assign wr_addr = tdfe_pkg::ADDR_W'(32'(inst_q) * tdfe_pkg::ENTRIES
	                                   + 32'(slot_q[tdfe_pkg::IDX_W-1:0]));

	always_ff @(posedge clk) begin
		if (cmd.scan_en) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= '{act: act_q, to: to_q, op: op_q, from: key_q};
	end

	assign hit       = issue_s1 && rd_s1.from == lookup_q && rd_s1.op == op_q;
	assign exhausted = !issue_s1 && idx_q >= n_q;
	assign need_scan = inst_ok && (cmd_q == tdfe_pkg::CMD_EVENT || cmd_q == tdfe_pkg::CMD_JUMP);
	assign stat.done = !need_scan || hit || exhausted;

	always_comb begin
		prev_old = inst_ok ? prev_q[inst_q] : '0;
		cur_old  = inst_ok ? cur_q[inst_q]  : '0;
		rop_old  = inst_ok ? rop_q[inst_q]  : '0;
		prev_n   = prev_old;
		cur_n    = cur_old;
		rop_n    = rop_old;
		wr_en    = 1'b0;
		res_n    = '0;
		if (inst_ok) begin
			case (cmd_q)
				tdfe_pkg::CMD_LOAD: begin
					wr_en         = cmd.commit && slot_ok;
					res_n.matched = slot_ok;
				end
				tdfe_pkg::CMD_EVENT: begin
					if (hit) begin
						prev_n              = cur_old;
						cur_n               = rd_s1.to;
						rop_n               = op_q;
						res_n.matched       = 1'b1;
						res_n.public_notify = cfg.notify_mask[inst_q];
					end
				end
				tdfe_pkg::CMD_FORCE: begin
					prev_n              = cur_old;
					cur_n               = key_q;
					rop_n               = op_q;
					res_n.matched       = 1'b1;
					res_n.public_notify = cfg.notify_mask[inst_q];
				end
				default: begin
					// jump: no common handler, recorded op untouched
					if (hit) begin
						prev_n        = rd_s1.from;
						cur_n         = rd_s1.to;
						res_n.matched = 1'b1;
					end
				end
			endcase
			if (hit && rd_s1.act && cmd_q != tdfe_pkg::CMD_LOAD
			    && cmd_q != tdfe_pkg::CMD_FORCE) begin
				res_n.action_notify = 1'b1;
				res_n.action_from   = 8'(rd_s1.from);
				res_n.action_to     = 8'(rd_s1.to);
			end
		end
		res_n.inst           = inst_q;
		res_n.prior_state    = 8'(prev_n);
		res_n.present_state  = 8'(cur_n);
		res_n.last_operation = rop_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cur_q  <= '0;
			rop_q  <= '0;
		end else if (cmd.commit && inst_ok) begin
			prev_q[inst_q] <= prev_n;
			cur_q[inst_q]  <= cur_n;
			rop_q[inst_q]  <= rop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) res_q <= res_n;
	end

	assign res = res_q;

endmodule

[rtl/table_driven_fsm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_driven_fsm_engine
// Programmable engine for three table-driven state machines.
// ----------------------------------------------------------------------------
// One beat is in flight at a time and every beat returns one result beat.
// Load and force commands commit without a table scan.
// Event and jump commands scan the instance's used table slots in order
// through the single read port of the table memory, one slot per cycle,
// registering each read before the compare, and stop at the first hit or
// after the last used slot (at most 16). A result waiting in the output
// register stalls only the completion of the next beat, not its acceptance.
// The table has no reset value; slots must be loaded before an event or
// jump reads them.
module table_driven_fsm_engine (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// instance_req[1:0], entry_slot[5:2], key_state[13:6], operation[21:14],
	// to_state[29:22], has_action[30], zero[31]
	input  logic [31:0] s_tdata,
	// command[1:0]
	input  logic [1:0]  s_tuser,
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// matched[0], instance_out[2:1], prior_state[10:3], present_state[18:11],
	// last_operation[26:19], public_notify[27], action_notify[28],
	// action_from[36:29], action_to[44:37], zero[47:45]
	output logic [47:0] m_tdata
);

	tdfe_pkg::cfg_t      cfg;
	tdfe_pkg::item_t     item;
	tdfe_pkg::res_t      res;
	tdfe_pkg::ctrl_cmd_t cmd;
	tdfe_pkg::dp_stat_t  stat;

	always_comb begin
		item.command    = s_tuser;
		item.inst       = s_tdata[1:0];
		item.slot       = s_tdata[5:2];
		item.key_state  = s_tdata[13:6];
		item.operation  = s_tdata[21:14];
		item.to_state   = s_tdata[29:22];
		item.has_action = s_tdata[30];
	end

	assign m_tdata = {3'b000, res.action_to, res.action_from, res.action_notify,
	                  res.public_notify, res.last_operation, res.present_state,
	                  res.prior_state, res.inst, res.matched};

	tdfe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tdfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdfe_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

endmodule

[rtl/tdfe_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdfe_chk
// Port-level checks for the table-driven state machine engine.
// ----------------------------------------------------------------------------
module tdfe_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one command in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second command taken while one is in flight");

	// unknown instance reports nothing but its number
	a_bad_inst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:1] == 2'd3 |-> m_tdata[0] == 1'b0 && m_tdata[44:3] == '0)
		else $error("result for unknown instance not clear");

	// action notify only on a match; otherwise action states are zero
	a_action: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[28] && m_tdata[0]) || (!m_tdata[28] && m_tdata[44:29] == '0))
		else $error("action fields inconsistent");

endmodule

bind table_driven_fsm_engine tdfe_chk u_tdfe_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
